// ===== design/bcms_pkg.sv =====
// Shared constants, types and the curvature operator for the binary curvature smoother.
`timescale 1ns / 1ps

package bcms_pkg;

   // Frame size limits and the counter widths that follow from them.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   // rows count up to the frame height plus two while the flush drains
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int RESET_WIDTH      = 640;
   localparam int RESET_HEIGHT     = 480;
   localparam int RESET_FIRST_MODE = 1;

   // Result queue.
   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_FIRST_MODE   = 2'd2
   } csr_index_type;

   // One line buffer entry: pixel one row up and two rows up at this column.
   typedef struct packed {
      logic mid;
      logic top;
   } line_pair_type;

   // One window column, top to bottom.
   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } col3_type;

   // 3x3 window, each row as {left, centre, right}.
   typedef struct packed {
      logic [2:0] top;
      logic [2:0] mid;
      logic [2:0] bot;
   } win3_type;

   // Which neighbours lie inside the frame.
   typedef struct packed {
      logic up;
      logic dn;
      logic lf;
      logic rt;
   } nbr_ok_type;

   typedef struct packed {
      logic pixel_out;
      logic last_of_frame;
   } rsp_item_type;

   // One 3-pixel line element; neighbours outside the frame drop out.
   function automatic logic line_op(logic c, logic na, logic oka, logic nb, logic okb,
                                    logic dil);
      logic r;
      if (dil) begin
         r = c | (oka & na) | (okb & nb);
      end else begin
         r = c & (~oka | na) & (~okb | nb);
      end
      return r;
   endfunction

   // dil: AND of four line dilations, else OR of four line erosions.
   function automatic logic curv_eval(win3_type w, nbr_ok_type ok, logic dil);
      logic [3:0] ln;
      logic       r;
      ln[0] = line_op(w.mid[1], w.top[2], ok.up & ok.lf, w.bot[0], ok.dn & ok.rt, dil);
      ln[1] = line_op(w.mid[1], w.mid[2], ok.lf, w.mid[0], ok.rt, dil);
      ln[2] = line_op(w.mid[1], w.top[0], ok.up & ok.rt, w.bot[2], ok.dn & ok.lf, dil);
      ln[3] = line_op(w.mid[1], w.top[1], ok.up, w.bot[1], ok.dn, dil);
      r = dil ? (&ln) : (|ln);
      return r;
   endfunction

endpackage

// ===== design/bcms_channels.sv =====
// Channel interfaces: pixel requests, smoothed responses and register writes.
`timescale 1ns / 1ps

interface bcms_req_if;
   logic valid;
   logic ready;
   logic pixel_in;
   logic is_flush;
   modport source (output valid, output pixel_in, output is_flush, input ready);
   modport sink (input valid, input pixel_in, input is_flush, output ready);
endinterface

interface bcms_rsp_if;
   logic valid;
   logic ready;
   logic pixel_out;
   logic last_of_frame;
   modport source (output valid, output pixel_out, output last_of_frame, input ready);
   modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

interface bcms_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bcms_pkg::CSR_IDX_W-1:0]  index;
   logic [bcms_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bcms_window.sv =====
// Two-row line buffer plus column taps that form a 3x3 window around the stream.
`timescale 1ns / 1ps

module bcms_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [bcms_pkg::COL_W-1:0] wr_col,
   input  logic [bcms_pkg::COL_W-1:0] rd_col,
   input  logic                       pix_new,
   output bcms_pkg::win3_type         win
);

   bcms_pkg::line_pair_type mem [bcms_pkg::MAX_WIDTH];
   bcms_pkg::line_pair_type rd_ff;
   bcms_pkg::line_pair_type byp_data_ff;
   bcms_pkg::line_pair_type rd_pair;
   bcms_pkg::line_pair_type wr_pair;
   logic                    bypass_ff;
   logic                    bypass_in;
   bcms_pkg::col3_type      newest;
   bcms_pkg::col3_type      tap1_ff;
   bcms_pkg::col3_type      tap2_ff;

   // read data is registered; a write to the same address in the read cycle is forwarded
   assign rd_pair = bypass_ff ? byp_data_ff : rd_ff;

   assign wr_pair.mid = pix_new;
   assign wr_pair.top = rd_pair.mid;

   assign newest.top = rd_pair.top;
   assign newest.mid = rd_pair.mid;
   assign newest.bot = pix_new;

   assign bypass_in = advance && (rd_col == wr_col);

   always_ff @(posedge clock) begin
      if (advance) begin
         mem[wr_col] <= wr_pair;
      end
      rd_ff       <= mem[rd_col];
      byp_data_ff <= wr_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tap1_ff <= newest;
         tap2_ff <= tap1_ff;
      end
   end

   assign win.top = {tap2_ff.top, tap1_ff.top, newest.top};
   assign win.mid = {tap2_ff.mid, tap1_ff.mid, newest.mid};
   assign win.bot = {tap2_ff.bot, tap1_ff.bot, newest.bot};

endmodule

// ===== design/bcms_rsp_fifo.sv =====
// Small result queue that decouples the pixel pipeline from the response channel.
`timescale 1ns / 1ps

module bcms_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  bcms_pkg::rsp_item_type         push_item,
   output logic [bcms_pkg::RSP_CNT_W-1:0] count,
   bcms_rsp_if.source                     rsp
);

   bcms_pkg::rsp_item_type           store [bcms_pkg::RSP_DEPTH];
   logic [bcms_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bcms_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bcms_pkg::RSP_CNT_W-1:0]   count_ff, count_in;
   logic                             pop;
   bcms_pkg::rsp_item_type           head;

   assign head              = store[rd_ptr_ff];
   assign rsp.valid         = (count_ff != '0);
   assign rsp.pixel_out     = head.pixel_out;
   assign rsp.last_of_frame = head.last_of_frame;
   assign pop               = rsp.valid && rsp.ready;
   assign count             = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bcms_pkg::RSP_PTR_W'(bcms_pkg::RSP_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bcms_pkg::RSP_PTR_W'(bcms_pkg::RSP_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/binary_curvature_morph_smoother.sv =====
// Binary curvature smoother: a binary frame streams in raster order, one pixel per
// transaction, and is smoothed by two 3x3 morphological stages built from four line
// elements (diagonal, horizontal, anti-diagonal, vertical); the dilate/erode order flips
// after every frame. Throughput is one transaction per clock while the result queue has room,
// set by the per-transaction update of the line buffers and window taps; a response passes the
// input register and the result queue before it leaves the block. The result for a pixel comes out
// 2*W+2 transactions after that pixel, so each frame of W*H pixels must be followed by
// 2*W+2 flush transactions; flush transactions sent while pixels are still expected are
// dropped. Register writes restart the frame and must only be issued while idle.
`timescale 1ns / 1ps

module binary_curvature_morph_smoother (
   input logic        clock,
   input logic        reset,
   bcms_req_if.sink   req_ch,
   bcms_rsp_if.source rsp_ch,
   bcms_csr_if.sink   csr_ch
);

   localparam int COL_W = bcms_pkg::COL_W;
   localparam int ROW_W = bcms_pkg::ROW_W;
   localparam int CNT_W = bcms_pkg::RSP_CNT_W;

   function automatic logic [COL_W-1:0] clamp_wm1(logic [bcms_pkg::CSR_DATA_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > bcms_pkg::MAX_WIDTH) begin
         r = COL_W'(bcms_pkg::MAX_WIDTH - 1);
      end else begin
         r = COL_W'(v - 1'b1);
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] clamp_hm1(logic [bcms_pkg::CSR_DATA_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (32'(v) > bcms_pkg::MAX_HEIGHT) begin
         r = ROW_W'(bcms_pkg::MAX_HEIGHT - 1);
      end else begin
         r = ROW_W'(v - 1'b1);
      end
      return r;
   endfunction

   // configuration
   logic [COL_W-1:0] wm1_ff, wm1_in;
   logic [ROW_W-1:0] hm1_ff, hm1_in;
   logic             first_mode_ff, first_mode_in;
   logic             csr_wr;

   // input register
   logic in_valid_ff, in_pix_ff, in_flush_ff;
   logic req_accept;

   // stream position counters
   logic [COL_W-1:0] in_col_ff, in_col_in, st_col_ff, st_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, st_row_ff, st_row_in, out_row_ff, out_row_in;
   logic             dilate_first_ff, dilate_first_in;

   logic                   pix_phase, proc, px, s1_on, s2_on, s_val, frame_end;
   bcms_pkg::nbr_ok_type   nbr1, nbr2;
   bcms_pkg::win3_type     win1, win2;
   bcms_pkg::rsp_item_type push_item;
   logic                   push;
   logic [CNT_W-1:0]       fifo_count;

   assign csr_ch.ready = 1'b1;
   assign csr_wr = csr_ch.valid && ((csr_ch.index == bcms_pkg::CSR_FRAME_WIDTH) ||
                                    (csr_ch.index == bcms_pkg::CSR_FRAME_HEIGHT) ||
                                    (csr_ch.index == bcms_pkg::CSR_FIRST_MODE));

   always_comb begin
      wm1_in        = wm1_ff;
      hm1_in        = hm1_ff;
      first_mode_in = first_mode_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            bcms_pkg::CSR_FRAME_WIDTH:  wm1_in = clamp_wm1(csr_ch.data);
            bcms_pkg::CSR_FRAME_HEIGHT: hm1_in = clamp_hm1(csr_ch.data);
            bcms_pkg::CSR_FIRST_MODE:   first_mode_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // one item in the input register is always drained, so count it against the queue
   assign req_ch.ready = ({1'b0, fifo_count} + (CNT_W + 1)'(in_valid_ff)) <
                         (CNT_W + 1)'(bcms_pkg::RSP_DEPTH);
   assign req_accept = req_ch.valid && req_ch.ready;

   // processing stage
   assign pix_phase = (in_row_ff <= hm1_ff);
   assign proc      = in_valid_ff && !(pix_phase && in_flush_ff);
   assign px        = pix_phase && in_pix_ff;

   // stage one starts W+1 items in, stage two W+1 stage-one items later
   assign s1_on = (in_row_ff >= ROW_W'(2)) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign s2_on = (st_row_ff >= ROW_W'(2)) || ((st_row_ff == ROW_W'(1)) && (st_col_ff != '0));

   assign nbr1.up = (st_row_ff != '0);
   assign nbr1.dn = (st_row_ff < hm1_ff);
   assign nbr1.lf = (st_col_ff != '0);
   assign nbr1.rt = (st_col_ff < wm1_ff);

   assign nbr2.up = (out_row_ff != '0);
   assign nbr2.dn = (out_row_ff < hm1_ff);
   assign nbr2.lf = (out_col_ff != '0);
   assign nbr2.rt = (out_col_ff < wm1_ff);

   assign s_val = s1_on && (st_row_ff <= hm1_ff) &&
                  bcms_pkg::curv_eval(win1, nbr1, dilate_first_ff);

   assign push                    = proc && s2_on;
   assign frame_end               = (out_row_ff == hm1_ff) && (out_col_ff == wm1_ff);
   assign push_item.pixel_out     = bcms_pkg::curv_eval(win2, nbr2, !dilate_first_ff);
   assign push_item.last_of_frame = frame_end;

   always_comb begin
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      st_col_in       = st_col_ff;
      st_row_in       = st_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      dilate_first_in = dilate_first_ff;
      if (csr_wr || (push && frame_end)) begin
         in_col_in       = '0;
         in_row_in       = '0;
         st_col_in       = '0;
         st_row_in       = '0;
         out_col_in      = '0;
         out_row_in      = '0;
         dilate_first_in = csr_wr ? first_mode_in : !dilate_first_ff;
      end else if (proc) begin
         if (in_col_ff == wm1_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (s1_on) begin
            if (st_col_ff == wm1_ff) begin
               st_col_in = '0;
               st_row_in = st_row_ff + 1'b1;
            end else begin
               st_col_in = st_col_ff + 1'b1;
            end
         end
         if (s2_on) begin
            if (out_col_ff == wm1_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff          <= clamp_wm1(bcms_pkg::CSR_DATA_W'(bcms_pkg::RESET_WIDTH));
         hm1_ff          <= clamp_hm1(bcms_pkg::CSR_DATA_W'(bcms_pkg::RESET_HEIGHT));
         first_mode_ff   <= 1'(bcms_pkg::RESET_FIRST_MODE);
         dilate_first_ff <= 1'(bcms_pkg::RESET_FIRST_MODE);
         in_valid_ff     <= 1'b0;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         st_col_ff       <= '0;
         st_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         wm1_ff          <= wm1_in;
         hm1_ff          <= hm1_in;
         first_mode_ff   <= first_mode_in;
         dilate_first_ff <= dilate_first_in;
         in_valid_ff     <= req_accept;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         st_col_ff       <= st_col_in;
         st_row_ff       <= st_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_pix_ff   <= req_ch.pixel_in;
         in_flush_ff <= req_ch.is_flush;
      end
   end

   // both line buffers are indexed by the column of the current stream position
   bcms_window u_win_input (
      .clock   (clock),
      .reset   (reset),
      .advance (proc),
      .wr_col  (in_col_ff),
      .rd_col  (in_col_in),
      .pix_new (px),
      .win     (win1)
   );

   bcms_window u_win_stage (
      .clock   (clock),
      .reset   (reset),
      .advance (proc),
      .wr_col  (in_col_ff),
      .rd_col  (in_col_in),
      .pix_new (s_val),
      .win     (win2)
   );

   bcms_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .count     (fifo_count),
      .rsp       (rsp_ch)
   );

   // the queue always has room for the item being processed
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (fifo_count < CNT_W'(bcms_pkg::RSP_DEPTH)))
      else $error("result queue full while an item is in process");

   // stage two never runs ahead of stage one
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      s2_on |-> s1_on)
      else $error("stage two active before stage one");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (push && frame_end) |=> ((in_row_ff == '0) && (in_col_ff == '0) &&
                               (out_row_ff == '0) && (out_col_ff == '0)))
      else $error("counters not cleared after last pixel of frame");

   a_mode_flip: assert property (@(posedge clock) disable iff (reset)
      (push && frame_end && !csr_wr) |=> (dilate_first_ff != $past(dilate_first_ff)))
      else $error("mode did not toggle at end of frame");

endmodule

// ===== tb/bcms_smoothing_checker.sv =====
// Checker for the binary curvature smoother: predicts smoothed pixels and compares responses.
`timescale 1ns / 1ps

module bcms_smoothing_checker
   import bcms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bcms_req_if        req_ch,
   bcms_rsp_if        rsp_ch,
   bcms_csr_if        csr_ch,
   output int         fail_count,
   output int         pending_count
);

   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   logic                  first_mode_reg;
   logic                  dilate_first;
   int                    frame_pos;
   int                    errors;
   bit                    in_frame[];
   bit                    stage_frame[];
   rsp_item_type          expected_pixels[$];

   function automatic int clamp_dim(logic [CSR_DATA_W-1:0] raw, int max_dim);
      if (raw == 0) return 1;
      if (raw > max_dim) return max_dim;
      return int'(raw);
   endfunction

   function automatic bit pel(bit from_input, int idx);
      return from_input ? in_frame[idx] : stage_frame[idx];
   endfunction

   // one 3-pixel line through (row, col) along +/-(dr, dc); outside neighbors drop out
   function automatic bit line_value(bit from_input, int row, int col, int dr, int dc,
                                     int w, int h, bit dil);
      bit v;
      bit nb;
      int rr;
      int cc;
      v = pel(from_input, row * w + col);
      for (int j = 0; j < 2; j++) begin
         rr = (j == 0) ? row + dr : row - dr;
         cc = (j == 0) ? col + dc : col - dc;
         if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
            nb = pel(from_input, rr * w + cc);
            v  = dil ? (v | nb) : (v & nb);
         end
      end
      return v;
   endfunction

   function automatic bit curvature(bit from_input, int row, int col, int w, int h,
                                    bit dil);
      bit diag;
      bit horiz;
      bit anti;
      bit vert;
      diag  = line_value(from_input, row, col, -1, -1, w, h, dil);
      horiz = line_value(from_input, row, col,  0, -1, w, h, dil);
      anti  = line_value(from_input, row, col, -1,  1, w, h, dil);
      vert  = line_value(from_input, row, col, -1,  0, w, h, dil);
      return dil ? (diag & horiz & anti & vert) : (diag | horiz | anti | vert);
   endfunction

   function automatic void restart_frame();
      frame_pos    = 0;
      dilate_first = first_mode_reg;
      in_frame     = new[clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT)];
      stage_frame  = new[in_frame.size()];
   endfunction

   always @(posedge clock) begin
      int           w;
      int           h;
      int           total;
      int           s;
      int           o;
      bit           last;
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         width_reg      = CSR_DATA_W'(RESET_WIDTH);
         height_reg     = CSR_DATA_W'(RESET_HEIGHT);
         first_mode_reg = (RESET_FIRST_MODE != 0);
         errors         = 0;
         expected_pixels.delete();
         restart_frame();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_FRAME_WIDTH: begin
                  width_reg = csr_ch.data;
                  restart_frame();
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_ch.data;
                  restart_frame();
               end
               CSR_FIRST_MODE: begin
                  first_mode_reg = csr_ch.data[0];
                  restart_frame();
               end
               default: ;
            endcase
         end

         if (req_ch.valid && req_ch.ready) begin
            w     = clamp_dim(width_reg, MAX_WIDTH);
            h     = clamp_dim(height_reg, MAX_HEIGHT);
            total = w * h;
            // flush while pixels are still expected is dropped
            if (!(frame_pos < total && req_ch.is_flush)) begin
               if (frame_pos < total) in_frame[frame_pos] = req_ch.pixel_in;
               if (frame_pos >= w + 1) begin
                  s = frame_pos - (w + 1);
                  if (s < total) stage_frame[s] = curvature(1'b1, s / w, s % w, w, h,
                                                            dilate_first);
               end
               last = 1'b0;
               if (frame_pos >= 2 * w + 2) begin
                  o                  = frame_pos - (2 * w + 2);
                  last               = (o == total - 1);
                  want.pixel_out     = curvature(1'b0, o / w, o % w, w, h, !dilate_first);
                  want.last_of_frame = last;
                  expected_pixels.push_back(want);
               end
               frame_pos++;
               if (last) begin
                  frame_pos    = 0;
                  dilate_first = !dilate_first;
               end
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pixel_out     = rsp_ch.pixel_out;
            got.last_of_frame = rsp_ch.last_of_frame;
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected transaction: pixel_out=%0b last_of_frame=%0b",
                           got.pixel_out, got.last_of_frame);
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel_out !== want.pixel_out ||
                   got.last_of_frame !== want.last_of_frame) begin
                  errors++;
                  if (errors <= 10)
                     $display("wrong pixel: expected pixel_out=%0b last_of_frame=%0b, got %s",
                              want.pixel_out, want.last_of_frame,
                              $sformatf("pixel_out=%0b last_of_frame=%0b",
                                        got.pixel_out, got.last_of_frame));
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_pixels.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the binary curvature smoother: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
   import bcms_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {FILL_RANDOM, FILL_CHECKER, FILL_DOT} fill_kind_type;

   logic clock;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   frame_w = RESET_WIDTH;
   int   frame_h = RESET_HEIGHT;
   int   fail_count;
   int   pending_count;

   bcms_req_if req_ch();
   bcms_rsp_if rsp_ch();
   bcms_csr_if csr_ch();

   binary_curvature_morph_smoother u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bcms_smoothing_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binary_curvature_morph_smoother: mismatch");
         $finish;
      end
   end

   function automatic int clamp_dim(logic [CSR_DATA_W-1:0] raw, int max_dim);
      if (raw == 0) return 1;
      if (raw > max_dim) return max_dim;
      return int'(raw);
   endfunction

   // valid stays high after acceptance so back-to-back transactions need no re-raise
   task automatic send_item(input bit px, input bit flush);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= px;
      req_ch.is_flush <= flush;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // which[i] selects register i; the spare index must leave the frame alone
   task automatic configure(input logic [3:0] which, input logic [CSR_DATA_W-1:0] w_raw,
                            input logic [CSR_DATA_W-1:0] h_raw,
                            input logic [CSR_DATA_W-1:0] mode_raw);
      wait_idle();
      if (which[CSR_FRAME_WIDTH]) begin
         write_reg(CSR_FRAME_WIDTH, w_raw);
         frame_w = clamp_dim(w_raw, MAX_WIDTH);
      end
      if (which[CSR_FRAME_HEIGHT]) begin
         write_reg(CSR_FRAME_HEIGHT, h_raw);
         frame_h = clamp_dim(h_raw, MAX_HEIGHT);
      end
      if (which[CSR_FIRST_MODE]) write_reg(CSR_FIRST_MODE, mode_raw);
      if (which[CSR_SPARE_INDEX]) write_reg(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   // one full frame plus its flush tail; noisy adds dropped flushes and pixels in the tail
   task automatic send_frame(input fill_kind_type fill, input int density, input bit noisy);
      int  row;
      int  col;
      bit  px;
      for (int i = 0; i < frame_w * frame_h; i++) begin
         row = i / frame_w;
         col = i % frame_w;
         case (fill)
            FILL_CHECKER: px = 1'((row + col) % 2);
            FILL_DOT:     px = (row == frame_h / 2) && (col == frame_w / 2);
            default:      px = ($urandom_range(99) < density);
         endcase
         if (noisy && $urandom_range(99) < 5) send_item(1'($urandom_range(1)), 1'b1);
         send_item(px, 1'b0);
      end
      for (int i = 0; i < 2 * frame_w + 2; i++) begin
         if (noisy && $urandom_range(99) < 10) send_item(1'($urandom_range(1)), 1'b0);
         else send_item(1'($urandom_range(1)), 1'b1);
      end
   endtask

   initial begin
      int pixels_sent;
      req_ch.valid    <= 1'b0;
      req_ch.pixel_in <= 1'b0;
      req_ch.is_flush <= 1'b0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= CSR_FRAME_WIDTH;
      csr_ch.data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: default mode, both modes on small patterns, clamped sizes, spare index
      configure(4'b0011, 12'd3, 12'd3, 12'd0);
      send_frame(FILL_CHECKER, 0, 1'b1);
      send_frame(FILL_DOT, 0, 1'b0);
      configure(4'b1111, 12'd0, 12'd0, 12'hFFE);
      send_frame(FILL_RANDOM, 100, 1'b1);
      configure(4'b1000, 12'd0, 12'd0, 12'd0);
      send_frame(FILL_RANDOM, 100, 1'b0);
      configure(4'b0111, 12'd4, 12'd2, 12'h001);
      send_frame(FILL_RANDOM, 100, 1'b0);
      send_frame(FILL_RANDOM, 0, 1'b0);

      // random frames under each flow-control profile
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         pixels_sent = 0;
         while (pixels_sent < 40) begin
            if ($urandom_range(2) == 0)
               configure(4'($urandom), CSR_DATA_W'($urandom_range(7)),
                         CSR_DATA_W'($urandom_range(6)), CSR_DATA_W'($urandom));
            send_frame(FILL_RANDOM, $urandom_range(100), $urandom_range(3) == 0);
            pixels_sent += frame_w * frame_h;
         end
      end

      // single-row and single-column frames
      idle_pct  = 0;
      stall_pct = 0;
      configure(4'b0011, 12'd8, 12'd1, 12'd0);
      send_frame(FILL_RANDOM, 50, 1'b0);
      configure(4'b0111, 12'd1, 12'd8, 12'hFFF);
      send_frame(FILL_RANDOM, 60, 1'b0);

      wait_idle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("binary_curvature_morph_smoother: match");
      end else begin
         $display("binary_curvature_morph_smoother: mismatch");
      end
      $finish;
   end

endmodule

// ===== binary_curvature_morph_smoother.f =====
design/bcms_pkg.sv
design/bcms_channels.sv
design/bcms_window.sv
design/bcms_rsp_fifo.sv
design/binary_curvature_morph_smoother.sv
tb/bcms_smoothing_checker.sv
tb/tb_top.sv
